FILE: design/hals_nmf_factor_update_top_macros.svh
// Assertion macros used by the checker of this block.
`ifndef HALS_NMF_FACTOR_UPDATE_TOP_MACROS_SVH
`define HALS_NMF_FACTOR_UPDATE_TOP_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define HNFU_ASSERT_CLK(label, ck, rn, prop, msg) \
	label: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Assertion on the block clock clk and reset arst_n.
`define HNFU_ASSERT(label, prop, msg) `HNFU_ASSERT_CLK(label, clk, arst_n, prop, msg)

`endif

FILE: design/hnfu_pkg.sv
package hnfu_pkg;

	localparam int DEF_MAX_COMPONENTS = 32;
	localparam int DEF_MAX_FEATURES   = 256;

	localparam int OP_W       = 3;
	localparam int ROW_W      = 5;
	localparam int COL_W      = 8;
	localparam int DATA_W     = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam int NC_W       = 6;
	localparam int NF_W       = 9;
	localparam int DIV_DVD_W  = 48;

	localparam logic [OP_W-1:0] OP_LOAD_SIGMA = 3'd0;
	localparam logic [OP_W-1:0] OP_LOAD_BETA  = 3'd1;
	localparam logic [OP_W-1:0] OP_LOAD_DELTA = 3'd2;
	localparam logic [OP_W-1:0] OP_RUN        = 3'd3;
	localparam logic [OP_W-1:0] OP_READ       = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_COMPONENTS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_FEATURES     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NONNEGATIVE_MODE = 2'd2;

	localparam logic [NC_W-1:0] RST_NUM_COMPONENTS   = 6'd32;
	localparam logic [NF_W-1:0] RST_NUM_FEATURES     = 9'd256;
	localparam logic            RST_NONNEGATIVE_MODE = 1'b1;

	localparam logic KIND_DONE = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fffffff;
	localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh80000000;

	typedef struct packed {
		logic load_sigma;
		logic load_beta;
		logic load_delta;
		logic read_issue;
		logic read_out;
		logic clear_flags;
		logic diag_issue;
		logic diag_check;
		logic set_zero_var;
		logic mac_issue;
		logic mac_first;
		logic div_start;
		logic write_back;
		logic done_out;
		logic nonneg;
	} hnfu_cmd_t;

	typedef struct packed {
		logic out_full;
		logic diag_zero;
		logic mac_idle;
		logic div_done;
	} hnfu_status_t;

endpackage

FILE: design/hnfu_req_if.sv
interface hnfu_req_if;
	logic                                    valid;
	logic                                    ready;
	logic [hnfu_pkg::OP_W-1:0]               operation;
	logic [hnfu_pkg::ROW_W-1:0]              row_index;
	logic [hnfu_pkg::COL_W-1:0]              column_index;
	logic signed [hnfu_pkg::DATA_W-1:0]      data_value;

	modport source(output valid, operation, row_index, column_index, data_value,
		input ready);
	modport sink(input valid, operation, row_index, column_index, data_value,
		output ready);
endinterface

FILE: design/hnfu_res_if.sv
interface hnfu_res_if;
	logic                               valid;
	logic                               ready;
	logic                               result_kind;
	logic signed [hnfu_pkg::DATA_W-1:0] result_value;
	logic                               zero_variance_flag;
	logic                               saturation_flag;

	modport source(output valid, result_kind, result_value, zero_variance_flag,
		saturation_flag, input ready);
	modport sink(input valid, result_kind, result_value, zero_variance_flag,
		saturation_flag, output ready);
endinterface

FILE: design/hnfu_div.sv
module hnfu_div (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  logic signed [hnfu_pkg::DIV_DVD_W-1:0]   dividend,
	input  logic signed [hnfu_pkg::DATA_W-1:0]      divisor,
	output logic [hnfu_pkg::DIV_DVD_W-1:0]          quotient,
	output logic                                    negative,
	output logic                                    done
);
	localparam int DW    = hnfu_pkg::DIV_DVD_W;
	localparam int VW    = hnfu_pkg::DATA_W;
	localparam int CNT_W = $clog2(DW);

	logic [DW-1:0]    quo_q;
	logic [VW-1:0]    rem_q;
	logic [VW-1:0]    dvs_q;
	logic             neg_q;
	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VW:0]      trial;
	logic             ge;

	// Restoring division on magnitudes, one quotient bit per cycle.
	assign trial = {rem_q, quo_q[DW-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
				if (cnt_q == CNT_W'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
			dvs_q <= divisor[VW-1] ? VW'(-divisor) : VW'(divisor);
			neg_q <= dividend[DW-1] ^ divisor[VW-1];
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? VW'(trial - {1'b0, dvs_q}) : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign negative = neg_q;
	assign done     = done_q;
endmodule

FILE: design/hnfu_dp.sv
module hnfu_dp #(
	parameter int MAX_COMPONENTS = hnfu_pkg::DEF_MAX_COMPONENTS,
	parameter int MAX_FEATURES   = hnfu_pkg::DEF_MAX_FEATURES,
	localparam int NW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1,
	localparam int PW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  hnfu_pkg::hnfu_cmd_t                 cmd,
	input  logic [NW-1:0]                       n_idx,
	input  logic [PW-1:0]                       p_idx,
	input  logic [NW-1:0]                       k_idx,
	input  logic [hnfu_pkg::ROW_W-1:0]          row_index,
	input  logic [hnfu_pkg::COL_W-1:0]          column_index,
	input  logic signed [hnfu_pkg::DATA_W-1:0]  data_value,
	input  logic                                res_ready,
	output logic                                res_valid,
	output logic                                res_kind,
	output logic signed [hnfu_pkg::DATA_W-1:0]  res_value,
	output logic                                res_zero_var,
	output logic                                res_sat,
	output hnfu_pkg::hnfu_status_t              status
);
	localparam int DW    = hnfu_pkg::DATA_W;
	localparam int QW    = hnfu_pkg::DIV_DVD_W;
	localparam int SDEP  = MAX_COMPONENTS * MAX_COMPONENTS;
	localparam int BDEP  = MAX_COMPONENTS * MAX_FEATURES;
	localparam int SAW   = (SDEP > 1) ? $clog2(SDEP) : 1;
	localparam int BAW   = (BDEP > 1) ? $clog2(BDEP) : 1;
	localparam int PRODW = 2 * DW - 16;
	localparam int ACC_W = PRODW + NW + 2;

	logic signed [DW-1:0] sigma_mem [SDEP];
	logic signed [DW-1:0] beta_mem  [BDEP];
	logic signed [DW-1:0] delta_mem [BDEP];

	logic signed [DW-1:0]    sig_rdata_q, beta_rdata_q, delta_rdata_q;
	logic signed [DW-1:0]    var_q;
	logic                    rd_ok_q;
	logic                    v_s1, first_s1, v_s2, first_s2;
	logic signed [PRODW-1:0] prod_s2;
	logic signed [DW-1:0]    delta_s2;
	logic signed [ACC_W-1:0] acc_q;
	logic                    zv_q, sat_q;
	logic                    out_valid_q, out_kind_q, out_zv_q, out_sat_q;
	logic signed [DW-1:0]    out_value_q;

	logic                    sig_ok, feat_ok;
	logic [SAW-1:0]          sig_raddr, sig_waddr;
	logic [BAW-1:0]          pay_baddr, own_baddr, beta_raddr, beta_waddr, mac_baddr;
	logic                    beta_we, delta_we;
	logic signed [DW-1:0]    beta_wdata, delta_wdata;
	logic signed [2*DW-1:0]  prod;
	logic                    num_sat;
	logic signed [DW-1:0]    num;
	logic [QW-1:0]           quo_mag;
	logic                    quo_neg, div_done;
	logic                    q_sat;
	logic signed [DW-1:0]    q;
	logic signed [DW:0]      bsum;
	logic                    b_sat;
	logic signed [DW-1:0]    b_val;

	assign sig_ok  = (int'(row_index) < MAX_COMPONENTS) && (int'(column_index) < MAX_COMPONENTS);
	assign feat_ok = (int'(row_index) < MAX_COMPONENTS) && (int'(column_index) < MAX_FEATURES);

	assign sig_waddr = SAW'(int'(row_index) * MAX_COMPONENTS + int'(column_index));
	assign sig_raddr = cmd.diag_issue ? SAW'(int'(n_idx) * MAX_COMPONENTS + int'(n_idx))
		: SAW'(int'(n_idx) * MAX_COMPONENTS + int'(k_idx));
	assign pay_baddr = BAW'(int'(row_index) * MAX_FEATURES + int'(column_index));
	assign own_baddr = BAW'(int'(n_idx) * MAX_FEATURES + int'(p_idx));
	assign mac_baddr = BAW'(int'(k_idx) * MAX_FEATURES + int'(p_idx));

	always_comb begin
		priority if (cmd.read_issue)
			beta_raddr = pay_baddr;
		else if (cmd.mac_issue)
			beta_raddr = mac_baddr;
		else
			beta_raddr = own_baddr;
	end

	assign beta_we     = (cmd.load_beta && feat_ok) || cmd.write_back;
	assign delta_we    = (cmd.load_delta && feat_ok) || cmd.write_back;
	assign beta_waddr  = cmd.write_back ? own_baddr : pay_baddr;
	assign beta_wdata  = cmd.write_back ? b_val : data_value;
	assign delta_wdata = cmd.write_back ? q : data_value;

	always_ff @(posedge clk) begin
		if (cmd.load_sigma && sig_ok)
			sigma_mem[sig_waddr] <= data_value;
		if (cmd.diag_issue || cmd.mac_issue)
			sig_rdata_q <= sigma_mem[sig_raddr];
	end

	always_ff @(posedge clk) begin
		if (beta_we)
			beta_mem[beta_waddr] <= beta_wdata;
		if (cmd.read_issue || cmd.mac_issue || cmd.div_start)
			beta_rdata_q <= beta_mem[beta_raddr];
	end

	always_ff @(posedge clk) begin
		if (delta_we)
			delta_mem[beta_waddr] <= delta_wdata;
		if (cmd.mac_first)
			delta_rdata_q <= delta_mem[own_baddr];
	end

	// Multiply-accumulate pipeline: memory read, product, accumulate.
	assign prod = sig_rdata_q * beta_rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.mac_issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= cmd.mac_first;
		first_s2 <= first_s1;
		prod_s2  <= prod[2*DW-1:16];
		delta_s2 <= delta_rdata_q;
		if (v_s2)
			acc_q <= (first_s2 ? ACC_W'(delta_s2) : acc_q) - ACC_W'(prod_s2);
		if (cmd.diag_check)
			var_q <= sig_rdata_q;
		if (cmd.read_issue)
			rd_ok_q <= feat_ok;
	end

	assign num_sat = !((&acc_q[ACC_W-1:DW-1]) || !(|acc_q[ACC_W-1:DW-1]));
	assign num     = num_sat ? (acc_q[ACC_W-1] ? hnfu_pkg::Q_MIN : hnfu_pkg::Q_MAX)
		: acc_q[DW-1:0];

	hnfu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({num, 16'b0}),
		.divisor  (var_q),
		.quotient (quo_mag),
		.negative (quo_neg),
		.done     (div_done)
	);

	// The quotient magnitude may reach 2^31 exactly only when its sign is negative.
	assign q_sat = quo_neg ? (quo_mag > QW'(48'h80000000)) : (quo_mag > QW'(48'h7fffffff));
	always_comb begin
		if (q_sat)
			q = quo_neg ? hnfu_pkg::Q_MIN : hnfu_pkg::Q_MAX;
		else if (quo_neg)
			q = DW'(-quo_mag[DW-1:0]);
		else
			q = quo_mag[DW-1:0];
	end

	assign bsum  = {beta_rdata_q[DW-1], beta_rdata_q} + {q[DW-1], q};
	assign b_sat = bsum[DW] != bsum[DW-1];
	always_comb begin
		if (b_sat)
			b_val = bsum[DW] ? hnfu_pkg::Q_MIN : hnfu_pkg::Q_MAX;
		else
			b_val = bsum[DW-1:0];
		if (cmd.nonneg && (b_val[DW-1] || b_val == '0))
			b_val = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zv_q  <= 1'b0;
			sat_q <= 1'b0;
		end else if (cmd.clear_flags) begin
			zv_q  <= 1'b0;
			sat_q <= 1'b0;
		end else begin
			if (cmd.set_zero_var)
				zv_q <= 1'b1;
			if (cmd.div_start && num_sat)
				sat_q <= 1'b1;
			if (cmd.write_back && (q_sat || b_sat))
				sat_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.read_out || cmd.done_out)
			out_valid_q <= 1'b1;
		else if (res_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.read_out || cmd.done_out) begin
			out_kind_q  <= cmd.read_out ? hnfu_pkg::KIND_READ : hnfu_pkg::KIND_DONE;
			out_value_q <= (cmd.read_out && rd_ok_q) ? beta_rdata_q : '0;
			out_zv_q    <= zv_q;
			out_sat_q   <= sat_q;
		end
	end

	assign res_valid    = out_valid_q;
	assign res_kind     = out_kind_q;
	assign res_value    = out_value_q;
	assign res_zero_var = out_zv_q;
	assign res_sat      = out_sat_q;

	assign status.out_full  = out_valid_q;
	assign status.diag_zero = sig_rdata_q == '0;
	assign status.mac_idle  = !v_s1 && !v_s2;
	assign status.div_done  = div_done;
endmodule

FILE: design/hnfu_ctrl.sv
module hnfu_ctrl #(
	parameter int MAX_COMPONENTS = hnfu_pkg::DEF_MAX_COMPONENTS,
	parameter int MAX_FEATURES   = hnfu_pkg::DEF_MAX_FEATURES,
	localparam int NW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1,
	localparam int PW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  req_valid,
	output logic                                  req_ready,
	input  logic [hnfu_pkg::OP_W-1:0]             operation,
	input  logic                                  res_ready,
	input  logic                                  cfg_we,
	input  logic [hnfu_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [hnfu_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  hnfu_pkg::hnfu_status_t                status,
	output hnfu_pkg::hnfu_cmd_t                   cmd,
	output logic [NW-1:0]                         n_idx,
	output logic [PW-1:0]                         p_idx,
	output logic [NW-1:0]                         k_idx
);
	localparam int NUW = $clog2(MAX_COMPONENTS + 1);
	localparam int PUW = $clog2(MAX_FEATURES + 1);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_READ     = 9'b000000010,
		S_DIAG_RD  = 9'b000000100,
		S_DIAG_CHK = 9'b000001000,
		S_MAC      = 9'b000010000,
		S_DRAIN    = 9'b000100000,
		S_DIV      = 9'b001000000,
		S_WB       = 9'b010000000,
		S_DONE     = 9'b100000000
	} state_t;

	state_t                      state_q, state_d;
	logic [hnfu_pkg::NC_W-1:0]   nc_q;
	logic [hnfu_pkg::NF_W-1:0]   nf_q;
	logic                        nonneg_q;
	logic [NW-1:0]               n_q, n_d, k_q, k_d;
	logic [PW-1:0]               p_q, p_d;
	logic [NUW-1:0]              n_use;
	logic [PUW-1:0]              p_use;
	logic [NW-1:0]               n_last;
	logic [PW-1:0]               p_last;
	logic                        accept;

	assign n_use  = (int'(nc_q) < MAX_COMPONENTS) ? NUW'(nc_q) : NUW'(MAX_COMPONENTS);
	assign p_use  = (int'(nf_q) < MAX_FEATURES) ? PUW'(nf_q) : PUW'(MAX_FEATURES);
	assign n_last = NW'(n_use - 1'b1);
	assign p_last = PW'(p_use - 1'b1);

	assign req_ready = (state_q == S_IDLE) && (!status.out_full || res_ready);
	assign accept    = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_q     <= hnfu_pkg::RST_NUM_COMPONENTS;
			nf_q     <= hnfu_pkg::RST_NUM_FEATURES;
			nonneg_q <= hnfu_pkg::RST_NONNEGATIVE_MODE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hnfu_pkg::CFG_NUM_COMPONENTS:   nc_q     <= cfg_data[hnfu_pkg::NC_W-1:0];
				hnfu_pkg::CFG_NUM_FEATURES:     nf_q     <= cfg_data[hnfu_pkg::NF_W-1:0];
				hnfu_pkg::CFG_NONNEGATIVE_MODE: nonneg_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q     <= '0;
			p_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			n_q     <= n_d;
			p_q     <= p_d;
			k_q     <= k_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		n_d        = n_q;
		p_d        = p_q;
		k_d        = k_q;
		cmd        = '0;
		cmd.nonneg = nonneg_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (operation)
						hnfu_pkg::OP_LOAD_SIGMA: cmd.load_sigma = 1'b1;
						hnfu_pkg::OP_LOAD_BETA:  cmd.load_beta  = 1'b1;
						hnfu_pkg::OP_LOAD_DELTA: cmd.load_delta = 1'b1;
						hnfu_pkg::OP_READ: begin
							cmd.read_issue = 1'b1;
							state_d        = S_READ;
						end
						hnfu_pkg::OP_RUN: begin
							cmd.clear_flags = 1'b1;
							n_d             = '0;
							p_d             = '0;
							k_d             = '0;
							if (n_use == '0 || p_use == '0)
								state_d = S_DONE;
							else
								state_d = S_DIAG_RD;
						end
						default: ;
					endcase
				end
			end
			S_READ: begin
				cmd.read_out = 1'b1;
				state_d      = S_IDLE;
			end
			S_DIAG_RD: begin
				cmd.diag_issue = 1'b1;
				state_d        = S_DIAG_CHK;
			end
			S_DIAG_CHK: begin
				cmd.diag_check = 1'b1;
				if (status.diag_zero) begin
					cmd.set_zero_var = 1'b1;
					if (n_q == n_last) begin
						state_d = S_DONE;
					end else begin
						n_d     = NW'(n_q + 1'b1);
						state_d = S_DIAG_RD;
					end
				end else begin
					p_d     = '0;
					k_d     = '0;
					state_d = S_MAC;
				end
			end
			S_MAC: begin
				cmd.mac_issue = 1'b1;
				cmd.mac_first = k_q == '0;
				if (k_q == n_last) begin
					k_d     = '0;
					state_d = S_DRAIN;
				end else begin
					k_d = NW'(k_q + 1'b1);
				end
			end
			S_DRAIN: begin
				if (status.mac_idle) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				if (status.div_done)
					state_d = S_WB;
			end
			S_WB: begin
				cmd.write_back = 1'b1;
				if (p_q == p_last) begin
					p_d = '0;
					if (n_q == n_last) begin
						state_d = S_DONE;
					end else begin
						n_d     = NW'(n_q + 1'b1);
						state_d = S_DIAG_RD;
					end
				end else begin
					p_d     = PW'(p_q + 1'b1);
					state_d = S_MAC;
				end
			end
			S_DONE: begin
				cmd.done_out = 1'b1;
				state_d      = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign n_idx = n_q;
	assign p_idx = p_q;
	assign k_idx = k_q;
endmodule

FILE: design/hals_nmf_factor_update_top.sv
// Channel   Direction  Payload
// request   in         operation, row_index, column_index, data_value
// result    out        result_kind, result_value, zero_variance_flag, saturation_flag
// cfg       in         cfg_we, cfg_index, cfg_data (write only)
//
// A load writes its store on acceptance; a read passes its word through the read
// register into the result register. A sweep fetches and checks the diagonal of each
// row, then per element runs the multiply-accumulate over N components, the pipeline
// drain, the bit-serial divider and the write-back.
// One request is worked on at a time; requests wait while a result is held.
// Reset clears the state machine and flags, sets the configuration to its defaults; stores stay unknown.
module hals_nmf_factor_update_top #(
	parameter int MAX_COMPONENTS = hnfu_pkg::DEF_MAX_COMPONENTS,
	parameter int MAX_FEATURES   = hnfu_pkg::DEF_MAX_FEATURES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	hnfu_req_if.sink                        request,
	hnfu_res_if.source                      result,
	input  logic                            cfg_we,
	input  logic [hnfu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hnfu_pkg::CFG_DATA_W-1:0] cfg_data
);
	localparam int NW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
	localparam int PW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

	hnfu_pkg::hnfu_cmd_t    cmd;
	hnfu_pkg::hnfu_status_t status;
	logic [NW-1:0]          n_idx, k_idx;
	logic [PW-1:0]          p_idx;

	hnfu_ctrl #(
		.MAX_COMPONENTS (MAX_COMPONENTS),
		.MAX_FEATURES   (MAX_FEATURES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.req_ready (request.ready),
		.operation (request.operation),
		.res_ready (result.ready),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.status    (status),
		.cmd       (cmd),
		.n_idx     (n_idx),
		.p_idx     (p_idx),
		.k_idx     (k_idx)
	);

	hnfu_dp #(
		.MAX_COMPONENTS (MAX_COMPONENTS),
		.MAX_FEATURES   (MAX_FEATURES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.n_idx        (n_idx),
		.p_idx        (p_idx),
		.k_idx        (k_idx),
		.row_index    (request.row_index),
		.column_index (request.column_index),
		.data_value   (request.data_value),
		.res_ready    (result.ready),
		.res_valid    (result.valid),
		.res_kind     (result.result_kind),
		.res_value    (result.result_value),
		.res_zero_var (result.zero_variance_flag),
		.res_sat      (result.saturation_flag),
		.status       (status)
	);
endmodule

FILE: design/hnfu_checker.sv
`include "hals_nmf_factor_update_top_macros.svh"

module hnfu_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               req_valid,
	input logic                               req_ready,
	input logic [hnfu_pkg::OP_W-1:0]          operation,
	input logic                               res_valid,
	input logic                               res_ready,
	input logic                               res_kind,
	input logic signed [hnfu_pkg::DATA_W-1:0] res_value
);
	logic read_accept;

	assign read_accept = req_valid && req_ready && (operation == hnfu_pkg::OP_READ);

	// A stalled result keeps its request open and its payload fixed.
	`HNFU_ASSERT(a_res_hold, (res_valid && !res_ready) |=> res_valid, "result dropped under stall")
	`HNFU_ASSERT(a_res_stable, (res_valid && !res_ready) |=> ($stable(res_value) && $stable(res_kind)), "result payload changed under stall")

	// A read blocks the next request and answers through the read register and then the result register.
	`HNFU_ASSERT(a_read_busy, read_accept |=> !req_ready, "request taken during a read")
	`HNFU_ASSERT(a_read_lat, read_accept |-> ##2 (res_valid && res_kind == hnfu_pkg::KIND_READ), "read result late")

	`HNFU_ASSERT(a_done_zero, (res_valid && res_kind == hnfu_pkg::KIND_DONE) |-> (res_value == '0), "sweep status carries a value")
endmodule

bind hals_nmf_factor_update_top hnfu_checker u_hnfu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (request.valid),
	.req_ready (request.ready),
	.operation (request.operation),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_kind  (result.result_kind),
	.res_value (result.result_value)
);
